// ===== sv/spf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam int SPF_CHANNELS_DEFAULT = 16;
    localparam int VAL_W                = 12;
    // Cell index width covers the largest supported channel count (64).
    localparam int CH_IDX_W             = 6;

    localparam logic [VAL_W-1:0] NO_PULSE   = 12'hFFF;
    localparam logic [VAL_W-1:0] WIDTH_MIN  = 12'd200;
    localparam logic [15:0]      PULSE_SPAN = 16'd200;   // width max minus width min
    localparam logic [8:0]       POS_OFFSET = 9'd127;

    typedef struct packed {
        logic                load;
        logic [CH_IDX_W-1:0] ch;
        logic [VAL_W-1:0]    value;
        logic                shift;
    } cell_ctrl_t;

    // 4095 - 200 - trunc((pos + 127) * 200 / 256); only pos = -128 gives a
    // negative product, and that truncates to zero.
    function automatic logic [VAL_W-1:0] pulse_from_position(input logic [7:0] pos);
        logic [8:0]  biased;
        logic [15:0] prod;
        logic [7:0]  span;
        biased = {pos[7], pos} + POS_OFFSET;
        prod   = {8'd0, biased[7:0]} * PULSE_SPAN;
        span   = biased[8] ? 8'd0 : prod[15:8];
        return NO_PULSE - WIDTH_MIN - {4'd0, span};
    endfunction

endpackage

`default_nettype wire

// ===== sv/spf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spf_cell
    import spf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [VAL_W-1:0] prev,
    output logic      [VAL_W-1:0] value
);

    localparam logic [CH_IDX_W-1:0] MY_IDX = CH_IDX_W'(IDX);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = prev;
        end
        else if (ctrl.load && (ctrl.ch == MY_IDX))
        begin
            value_next = ctrl.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= NO_PULSE;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== sv/spf_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spf_chain
    import spf_pkg::*;
#(
    parameter int CHANNELS = SPF_CHANNELS_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    output logic      [VAL_W-1:0] top_value,
    output logic      [VAL_W-1:0] sub_value
);

    logic [VAL_W-1:0] cell_val [CHANNELS];

    // Ring: each cell takes its lower neighbor, cell 0 takes the top cell.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        spf_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (cell_val[(i + CHANNELS - 1) % CHANNELS]),
            .value (cell_val[i])
        );
    end

    assign top_value = cell_val[CHANNELS-1];
    assign sub_value = cell_val[CHANNELS-2];

endmodule

`default_nettype wire

// ===== sv/servo_pwm_frame_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata bits                          tuser  tlast
// s_axis    in   [3:0] channel, [11:4] position      -      -
// m_axis    out  [7:0] data_byte                     -      last_byte
//
// Each accepted write is followed by (CHANNELS/2)*3 byte transfers, one per
// cycle while m_tready holds; odd CHANNELS adds a realign state (ST_ALIGN)
// after the last byte. The ring of cells rotates one step after the second
// and third byte of each pair. s_tready is high only between frames.
// While bytes are emitted, a stalled output holds the ring.
// Reset sets every channel to 4095 and empties the output register.

module servo_pwm_frame_packer
    import spf_pkg::*;
#(
    parameter int CHANNELS = SPF_CHANNELS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [3:0] channel, [11:4] position
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] data_byte
    output logic             m_tlast
);

    localparam int   PAIRS       = CHANNELS / 2;
    localparam int   FRAME_BYTES = PAIRS * 3;
    localparam int   BYTE_W      = $clog2(FRAME_BYTES);
    localparam bit   ODD_CH      = (CHANNELS % 2) != 0;
    localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_ALIGN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [1:0]        part_reg, part_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        odata_reg, odata_next;
    logic              olast_reg, olast_next;

    cell_ctrl_t        ctrl;
    logic [VAL_W-1:0]  top_value;
    logic [VAL_W-1:0]  sub_value;
    logic              in_xfer;
    logic              advance;
    logic [7:0]        cur_byte;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign advance  = !ovalid_reg || m_tready;

    always_comb
    begin
        case (part_reg)
            2'd0:    cur_byte = top_value[11:4];
            2'd1:    cur_byte = {top_value[3:0], sub_value[11:8]};
            default: cur_byte = top_value[7:0];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        byte_next   = byte_reg;
        part_next   = part_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;

        ctrl.load   = in_xfer;
        ctrl.ch     = {{(CH_IDX_W-4){1'b0}}, s_tdata[3:0]};
        ctrl.value  = pulse_from_position(s_tdata[11:4]);
        ctrl.shift  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EMIT;
                    byte_next  = '0;
                    part_next  = 2'd0;
                end
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = cur_byte;
                    olast_next  = (byte_reg == LAST_BYTE);
                    ctrl.shift  = (part_reg != 2'd0);
                    part_next   = (part_reg == 2'd2) ? 2'd0 : part_reg + 2'd1;
                    byte_next   = byte_reg + BYTE_W'(1);
                    if (byte_reg == LAST_BYTE)
                    begin
                        state_next = ODD_CH ? ST_ALIGN : ST_IDLE;
                    end
                end
            end
            ST_ALIGN:
            begin
                // odd ring: one more step brings every channel home
                ctrl.shift = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            byte_reg   <= '0;
            part_reg   <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            byte_reg   <= byte_next;
            part_reg   <= part_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    spf_chain #(
        .CHANNELS (CHANNELS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .top_value (top_value),
        .sub_value (sub_value)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire
